FILE: rtl/tts_pkg.sv
package tts_pkg;

    // Screen geometry.
    localparam int ROWS   = 4;
    localparam int COLS   = 20;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    // Field widths of the words on the ports.
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 2;
    localparam int COL_W  = 5;

    // Special byte values.
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    // Operation codes carried by each input word.
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Next cursor state and the cell-store actions for one word.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] top;
        logic             scrolled;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic             clr_all;
        logic             clr_row_en;
        logic [ROW_W-1:0] clr_row;
    } cur_upd_t;

    // Physical row of a screen row, given the row shown at the top.
    function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W-1:0] base,
                                                 input logic [ROW_W-1:0] offs);
        logic [ROW_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= (ROW_W + 1)'(ROWS)) begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // Linear cell address of a physical row and a column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
    endfunction

endpackage

FILE: rtl/tts_ram.sv
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/tts_cursor.sv
module tts_cursor
    import tts_pkg::*;
(
    input  op_t               op,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [ROW_W-1:0]  row,
    input  logic [COL_W-1:0]  col,
    input  logic [ROW_W-1:0]  top,
    output cur_upd_t          upd
);

    logic need_next;

    // Cursor movement, wrap and scroll decision for one word.
    always_comb begin
        need_next      = 1'b0;
        upd.row        = row;
        upd.col        = col;
        upd.top        = top;
        upd.scrolled   = 1'b0;
        upd.wr_en      = 1'b0;
        upd.wr_row     = wrap_row(top, row);
        upd.clr_all    = 1'b0;
        upd.clr_row_en = 1'b0;
        upd.clr_row    = top;

        case (op)
            OP_PUT: begin
                if (char_code == NEWLINE_CODE) begin
                    need_next = 1'b1;
                end else begin
                    upd.wr_en = 1'b1;
                    if (32'(col) + 1 >= COLS) begin
                        need_next = 1'b1;
                    end else begin
                        upd.col = col + 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                upd.row     = '0;
                upd.col     = '0;
                upd.top     = '0;
                upd.clr_all = 1'b1;
            end
            default: begin
            end
        endcase

        // Step to the next row; past the bottom the oldest row is blanked
        // and becomes the new bottom row.
        if (need_next) begin
            upd.col = '0;
            if (32'(row) + 1 >= ROWS) begin
                upd.clr_row_en = 1'b1;
                upd.top        = wrap_row(top, ROW_W'(1));
                upd.row        = ROW_W'(ROWS - 1);
                upd.scrolled   = 1'b1;
            end else begin
                upd.row = row + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/text_terminal_screen_buffer.sv
// Channel   Ports                                          Direction
// input     s_valid s_ready s_op s_char_code s_read_row    in
//           s_read_col
// result    m_valid m_ready m_read_char m_cursor_row       out
//           m_cursor_col m_scrolled
//
// A word goes from input to result through an input register, then one
// pass through the cursor logic and the cell memory's registered read port.
// One word is accepted every cycle while the result side keeps taking words.
// Reset clears the cursor, the top-row index and the per-cell valid bits at
// once, so the screen reads as all spaces with no clearing pass.
// A stalled result holds both stages; the input register still takes a word
// when it is empty.
module text_terminal_screen_buffer
    import tts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [CHAR_W-1:0] s_char_code,
    input  logic [ROW_W-1:0]  s_read_row,
    input  logic [COL_W-1:0]  s_read_col,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_read_char,
    output logic [ROW_W-1:0]  m_cursor_row,
    output logic [COL_W-1:0]  m_cursor_col,
    output logic              m_scrolled
);

    // Input stage.
    logic              in_valid_reg;
    op_t               op_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ROW_W-1:0]  rrow_reg;
    logic [COL_W-1:0]  rcol_reg;

    // Screen state.
    logic [ROW_W-1:0]  cur_row_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  top_reg;
    logic [CELLS-1:0]  cell_valid_reg;
    logic [CELLS-1:0]  cell_valid_next;

    // Result stage.
    logic              out_valid_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic              out_scr_reg;
    logic              out_rd_reg;
    logic              out_cell_valid_reg;

    logic              advance;
    logic              fire;
    logic              rd_in_range;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAR_W-1:0] ram_q;
    cur_upd_t          upd;

    // Pipeline flow control.
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= op_t'(s_op);
            char_reg <= s_char_code;
            rrow_reg <= s_read_row;
            rcol_reg <= s_read_col;
        end
    end

    // Cursor and scroll logic.
    tts_cursor u_cursor (
        .op        (op_reg),
        .char_code (char_reg),
        .row       (cur_row_reg),
        .col       (cur_col_reg),
        .top       (top_reg),
        .upd       (upd)
    );

    // Cell addresses for the write and the read.
    assign wr_addr     = cell_addr(upd.wr_row, cur_col_reg);
    assign rd_in_range = (op_reg == OP_READ) && (32'(rrow_reg) < ROWS)
                         && (32'(rcol_reg) < COLS);
    assign rd_addr     = rd_in_range ? cell_addr(wrap_row(top_reg, rrow_reg), rcol_reg)
                                     : '0;

    tts_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (fire && upd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (char_reg),
        .rd_en   (fire && rd_in_range),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Valid bits: a cell that is not valid reads as a space.
    always_comb begin
        cell_valid_next = cell_valid_reg;
        if (upd.clr_all) begin
            cell_valid_next = '0;
        end
        if (upd.clr_row_en) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    if (upd.clr_row == ROW_W'(r)) begin
                        cell_valid_next[r * COLS + c] = 1'b0;
                    end
                end
            end
        end
        if (upd.wr_en) begin
            cell_valid_next[wr_addr] = 1'b1;
        end
    end

    // Screen state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            cell_valid_reg <= '0;
        end else if (fire) begin
            cur_row_reg    <= upd.row;
            cur_col_reg    <= upd.col;
            top_reg        <= upd.top;
            cell_valid_reg <= cell_valid_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_row_reg        <= upd.row;
            out_col_reg        <= upd.col;
            out_scr_reg        <= upd.scrolled;
            out_rd_reg         <= rd_in_range;
            out_cell_valid_reg <= cell_valid_reg[rd_addr];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_cursor_row = out_row_reg;
    assign m_cursor_col = out_col_reg;
    assign m_scrolled   = out_scr_reg;
    assign m_read_char  = !out_rd_reg         ? '0 :
                          out_cell_valid_reg  ? ram_q : SPACE_CODE;

endmodule

FILE: dv/text_terminal_screen_buffer_tb.sv
`timescale 1ns / 1ps

module text_terminal_screen_buffer_tb;
    import tts_pkg::*;

    // The op code left unused by the block.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_WORDS  = 1130;
    localparam int PAUSE_AT      = 800;
    localparam int QUIET_FIRST   = 400;
    localparam int QUIET_LAST    = 599;
    localparam int IDLE_PERCENT  = 35;
    localparam int DRAIN_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIRECTED_LEN  = 22;

    // One result word as the block reports it.
    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              scrolled;
    } screen_result_t;

    // One directed input word; typed rows carry a hand-written result.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        logic              typed;
        screen_result_t    want;
    } directed_word_t;

    localparam directed_word_t DIRECTED [DIRECTED_LEN] = '{
        // Fresh screen reads as spaces; out-of-range columns and the unused op read as zero.
        '{OP_READ,   8'h00, 2'd0, 5'd0,  1'b1, '{8'h20, 2'd0, 5'd0, 1'b0}},
        '{OP_READ,   8'h00, 2'd3, 5'd19, 1'b1, '{8'h20, 2'd0, 5'd0, 1'b0}},
        '{OP_READ,   8'h00, 2'd2, 5'd31, 1'b1, '{8'h00, 2'd0, 5'd0, 1'b0}},
        '{OP_READ,   8'h00, 2'd1, 5'd20, 1'b1, '{8'h00, 2'd0, 5'd0, 1'b0}},
        '{OP_UNUSED, 8'hFF, 2'd3, 5'd31, 1'b1, '{8'h00, 2'd0, 5'd0, 1'b0}},
        // Byte extremes are stored as plain bytes.
        '{OP_PUT,    8'h00, 2'd0, 5'd0,  1'b1, '{8'h00, 2'd0, 5'd1, 1'b0}},
        '{OP_PUT,    8'hFF, 2'd0, 5'd0,  1'b1, '{8'h00, 2'd0, 5'd2, 1'b0}},
        '{OP_PUT,    NEWLINE_CODE, 2'd0, 5'd0, 1'b1, '{8'h00, 2'd1, 5'd0, 1'b0}},
        '{OP_READ,   8'h00, 2'd0, 5'd0,  1'b1, '{8'h00, 2'd1, 5'd0, 1'b0}},
        '{OP_READ,   8'h00, 2'd0, 5'd1,  1'b1, '{8'hFF, 2'd1, 5'd0, 1'b0}},
        '{OP_PUT,    8'h41, 2'd0, 5'd0,  1'b1, '{8'h00, 2'd1, 5'd1, 1'b0}},
        '{OP_PUT,    NEWLINE_CODE, 2'd0, 5'd0, 1'b1, '{8'h00, 2'd2, 5'd0, 1'b0}},
        '{OP_PUT,    NEWLINE_CODE, 2'd0, 5'd0, 1'b1, '{8'h00, 2'd3, 5'd0, 1'b0}},
        // A newline on the bottom row scrolls the screen.
        '{OP_PUT,    NEWLINE_CODE, 2'd0, 5'd0, 1'b1, '{8'h00, 2'd3, 5'd0, 1'b1}},
        '{OP_READ,   8'h00, 2'd0, 5'd0,  1'b0, '0},
        '{OP_READ,   8'h00, 2'd3, 5'd0,  1'b0, '0},
        '{OP_PUT,    8'h5A, 2'd0, 5'd0,  1'b0, '0},
        '{OP_PUT,    NEWLINE_CODE, 2'd0, 5'd0, 1'b0, '0},
        '{OP_UNUSED, NEWLINE_CODE, 2'd2, 5'd7, 1'b0, '0},
        // Clear homes the cursor and blanks everything.
        '{OP_CLEAR,  8'h00, 2'd0, 5'd0,  1'b1, '{8'h00, 2'd0, 5'd0, 1'b0}},
        '{OP_READ,   8'h00, 2'd0, 5'd0,  1'b1, '{8'h20, 2'd0, 5'd0, 1'b0}},
        '{OP_READ,   8'h00, 2'd3, 5'd19, 1'b1, '{8'h20, 2'd0, 5'd0, 1'b0}}
    };

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_op        = OP_PUT;
    logic [CHAR_W-1:0] s_char_code = '0;
    logic [ROW_W-1:0]  s_read_row  = '0;
    logic [COL_W-1:0]  s_read_col  = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [CHAR_W-1:0] m_read_char;
    logic [ROW_W-1:0]  m_cursor_row;
    logic [COL_W-1:0]  m_cursor_col;
    logic              m_scrolled;

    text_terminal_screen_buffer uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_char_code  (s_char_code),
        .s_read_row   (s_read_row),
        .s_read_col   (s_read_col),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_char  (m_read_char),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col),
        .m_scrolled   (m_scrolled)
    );

    always #10 aclk = ~aclk;

    // Screen contents and cursor as the block should hold them.
    logic [CHAR_W-1:0] screen_mem [CELLS];
    int                cur_row;
    int                cur_col;
    int                top_idx;
    screen_result_t    pending_results [$];

    bit          quiet_stretch = 1'b0;
    int unsigned error_count   = 0;
    int unsigned words_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned scrolls_seen  = 0;
    int unsigned reads_sent    = 0;
    int unsigned clears_sent   = 0;
    int unsigned cycle_count   = 0;

    function automatic int cell_index(int screen_row, int col);
        return ((top_idx + screen_row) % ROWS) * COLS + col;
    endfunction

    // Step the cursor to the next line, scrolling when it falls off the bottom.
    function automatic logic next_line();
        cur_col = 0;
        if (cur_row + 1 >= ROWS) begin
            for (int c = 0; c < COLS; c++) begin
                screen_mem[top_idx * COLS + c] = SPACE_CODE;
            end
            top_idx = (top_idx + 1) % ROWS;
            cur_row = ROWS - 1;
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    // Apply one accepted word to the screen and return the result it causes.
    function automatic screen_result_t screen_step(input logic [OP_W-1:0] op,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [ROW_W-1:0] rr,
                                                   input logic [COL_W-1:0] rc);
        screen_result_t res;
        res = '0;
        case (op)
            OP_PUT: begin
                if (ch == NEWLINE_CODE) begin
                    res.scrolled = next_line();
                end else begin
                    screen_mem[cell_index(cur_row, cur_col)] = ch;
                    cur_col++;
                    if (cur_col >= COLS) begin
                        res.scrolled = next_line();
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen_mem[i] = SPACE_CODE;
                end
                cur_row = 0;
                cur_col = 0;
                top_idx = 0;
            end
            OP_READ: begin
                if (rr < ROWS && rc < COLS) begin
                    res.read_char = screen_mem[cell_index(int'(rr), int'(rc))];
                end
            end
            default: begin
            end
        endcase
        res.row = cur_row[ROW_W-1:0];
        res.col = cur_col[COL_W-1:0];
        return res;
    endfunction

    // Offer one word, wait for the handshake, then record what it should give.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                             input logic typed, input screen_result_t want);
        screen_result_t predicted;
        while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_char_code <= ch;
        s_read_row  <= rr;
        s_read_col  <= rc;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = screen_step(op, ch, rr, rc);
        pending_results.push_back(typed ? want : predicted);
        words_sent++;
        if (op == OP_READ) begin
            reads_sent++;
        end
        if (op == OP_CLEAR) begin
            clears_sent++;
        end
    endtask

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Result side stalls at random, except through the quiet stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Compare each result word against the oldest pending prediction.
    always @(posedge aclk) begin
        screen_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, actual char %0d row %0d col %0d",
                         $time, m_read_char, m_cursor_row, m_cursor_col);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("read_char", int'(want.read_char), int'(m_read_char));
                check_field("cursor_row", int'(want.row), int'(m_cursor_row));
                check_field("cursor_col", int'(want.col), int'(m_cursor_col));
                check_field("scrolled", int'(want.scrolled), int'(m_scrolled));
                scrolls_seen += 32'(m_scrolled);
            end
        end
    end

    // Run watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int                pick;
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;

        for (int i = 0; i < CELLS; i++) begin
            screen_mem[i] = SPACE_CODE;
        end
        cur_row = 0;
        cur_col = 0;
        top_idx = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words first.
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            send_word(DIRECTED[i].op, DIRECTED[i].ch, DIRECTED[i].rr, DIRECTED[i].rc,
                      DIRECTED[i].typed, DIRECTED[i].want);
        end

        // Random words: mostly text with newlines, some reads, rare clears and unused ops.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            quiet_stretch = (i >= QUIET_FIRST && i <= QUIET_LAST);
            if (i == PAUSE_AT) begin
                s_valid <= 1'b0;
                do begin
                    @(posedge aclk);
                end while (pending_results.size() != 0);
            end
            pick = $urandom_range(0, 999);
            rr   = ROW_W'($urandom_range(0, 3));
            rc   = ($urandom_range(0, 99) < 85) ? COL_W'($urandom_range(0, COLS - 1))
                                                : COL_W'($urandom_range(COLS, 31));
            ch   = CHAR_W'($urandom_range(0, 255));
            if (pick < 700) begin
                op = OP_PUT;
                if ($urandom_range(0, 99) < 10) begin
                    ch = NEWLINE_CODE;
                end else if ($urandom_range(0, 99) < 75) begin
                    ch = CHAR_W'($urandom_range(32, 126));
                end
            end else if (pick < 985) begin
                op = OP_READ;
            end else if (pick < 995) begin
                op = OP_CLEAR;
            end else begin
                op = OP_UNUSED;
            end
            send_word(op, ch, rr, rc, 1'b0, '0);
        end
        quiet_stretch = 1'b0;

        // Let every outstanding result come back, then let the bench idle before the summary.
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words (%0d reads, %0d clears); checked %0d results, %0d scrolls.",
                 words_sent, reads_sent, clears_sent, results_seen, scrolls_seen);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/tts_pkg.sv
rtl/tts_ram.sv
rtl/tts_cursor.sv
rtl/text_terminal_screen_buffer.sv
dv/text_terminal_screen_buffer_tb.sv
